FILE: design/pba_pkg.sv
// Shared types, constants and command codes for the page bitmap allocator.
// Used by every interface and module of the block but pba_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pba_pkg;

  // Sizing of the managed page space.
  localparam int unsigned MAX_PAGES  = 32768;
  localparam int unsigned PAGE_SHIFT = 12;

  // Fixed field widths of the channels.
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned PAGE_ADDR_W = 32;
  localparam int unsigned FREE_W      = 16;
  localparam int unsigned CFG_W       = 16;

  // Derived widths of the internal state.
  localparam int unsigned CNT_W     = $clog2(MAX_PAGES + 1);
  localparam int unsigned PIDX_W    = $clog2(MAX_PAGES);
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned BIT_IDX_W = 3;
  localparam int unsigned MAP_DEPTH = (MAX_PAGES + BYTE_W - 1) / BYTE_W;
  localparam int unsigned MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int unsigned PN_W      = ADDR_W - PAGE_SHIFT;

  // Command queue between the front and the back end.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [KIND_W-1:0]      kind_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [PAGE_ADDR_W-1:0] page_addr_t;
  typedef logic [FREE_W-1:0]      free_t;
  typedef logic [CFG_W-1:0]       cfg_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [PIDX_W-1:0]      pidx_t;
  typedef logic [BYTE_W-1:0]      map_byte_t;
  typedef logic [MAP_AW-1:0]      map_addr_t;
  typedef logic [BIT_IDX_W-1:0]   bit_idx_t;
  typedef logic [PN_W-1:0]        pn_t;
  typedef logic [QPTR_W-1:0]      qptr_t;
  typedef logic [QCNT_W-1:0]      qcnt_t;

  // Value of the page-count register after reset.
  localparam cfg_t NUM_PAGES_RESET = cfg_t'(32768);

  // Mask of the byte offset inside one page.
  localparam addr_t PAGE_ROUND = addr_t'((64'd1 << PAGE_SHIFT) - 64'd1);

  // Item kinds as they arrive on the input channel.
  typedef enum logic [KIND_W-1:0] {
    KIND_RESERVE  = 2'd0,
    KIND_RELEASE  = 2'd1,
    KIND_ALLOC    = 2'd2,
    KIND_FREE_ONE = 2'd3
  } kind_e;

  // Operations handed from the front to the back end.
  typedef enum logic [1:0] {
    OP_NOP   = 2'd0,
    OP_MARK  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_ALLOC = 2'd3
  } op_e;

  // One command: an operation over the page range [lo, hi).
  typedef struct packed {
    op_e  op;
    cnt_t lo;
    cnt_t hi;
  } cmd_t;

endpackage

`default_nettype wire

FILE: design/pba_item_if.sv
// Input channel of the page bitmap allocator: one item per transfer.
// Depends on pba_pkg for the field types.
`timescale 1ns / 1ps
`default_nettype none

interface pba_item_if;
  logic            valid;
  logic            ready;
  pba_pkg::kind_t  kind;
  pba_pkg::addr_t  address;
  pba_pkg::addr_t  length;

  modport source (output valid, output kind, output address, output length, input ready);
  modport sink   (input valid, input kind, input address, input length, output ready);
endinterface

`default_nettype wire

FILE: design/pba_result_if.sv
// Result channel of the page bitmap allocator: one result per transfer.
// Depends on pba_pkg for the field types.
`timescale 1ns / 1ps
`default_nettype none

interface pba_result_if;
  logic                valid;
  logic                ready;
  pba_pkg::page_addr_t page_address;
  logic                out_of_memory;
  pba_pkg::free_t      free_pages;

  modport source (output valid, output page_address, output out_of_memory,
                  output free_pages, input ready);
  modport sink   (input valid, input page_address, input out_of_memory,
                  input free_pages, output ready);
endinterface

`default_nettype wire

FILE: design/pba_cfg_if.sv
// Configuration write channel: carries the page-count register value.
// Depends on pba_pkg for the data type.
`timescale 1ns / 1ps
`default_nettype none

interface pba_cfg_if;
  logic          valid;
  logic          ready;
  pba_pkg::cfg_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: design/page_bitmap_allocator.sv
// Top level of the page bitmap allocator: page-count register, front end,
// command queue and back end. Depends on pba_pkg, the channel interfaces,
// pba_front, pba_cmd_q and pba_back.
//
// Physical page allocator over a one-bit-per-page map held in a 4096 x 8 RAM.
// After reset the block runs a clearing pass that marks every page used. No
// item is taken during the clearing pass, although the page-count register
// may already be written then. Afterwards the register should only be
// written while no item is in flight, because the back end reads it throughout
// a walk. Each item then gives exactly one result. The front end does the
// 64-bit rounding and clipping; the back end reads every page-map byte that
// the item touches and writes it back at the same address, but for a byte in
// which an allocation finds no free page. A single free touches one byte, and
// an allocation one when the next free page lies in the cursor's byte; a range
// over all 32768 pages or a failing allocation search walks the whole map. The
// front end accepts the next item while the back end is still busy and while
// a result waits to be taken, as long as the command queue has room.
`timescale 1ns / 1ps
`default_nettype none

module page_bitmap_allocator (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  pba_item_if.sink     item_i,
  pba_result_if.source result_o,
  pba_cfg_if.sink      cfg_i
);

  pba_pkg::cfg_t num_pages_q;
  pba_pkg::cnt_t n_pages;
  logic          clearing;
  logic          fe_cmd_valid;
  pba_pkg::cmd_t fe_cmd;
  logic          fe_cmd_ready;
  logic          be_cmd_valid;
  pba_pkg::cmd_t be_cmd;
  logic          be_cmd_ready;

  // Page-count register; values above the map size act as the map size.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_pages_q <= pba_pkg::NUM_PAGES_RESET;
    end else if (cfg_i.valid) begin
      num_pages_q <= cfg_i.data;
    end
  end

  assign n_pages = (32'(num_pages_q) > 32'(pba_pkg::MAX_PAGES)) ?
                   pba_pkg::cnt_t'(pba_pkg::MAX_PAGES) : pba_pkg::cnt_t'(num_pages_q);

  pba_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item        (item_i),
    .n_pages_i   (n_pages),
    .block_i     (clearing),
    .cmd_valid_o (fe_cmd_valid),
    .cmd_o       (fe_cmd),
    .cmd_ready_i (fe_cmd_ready)
  );

  pba_cmd_q u_cmd_q (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_cmd_valid),
    .push_cmd_i   (fe_cmd),
    .push_ready_o (fe_cmd_ready),
    .pop_valid_o  (be_cmd_valid),
    .pop_cmd_o    (be_cmd),
    .pop_ready_i  (be_cmd_ready)
  );

  pba_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_pages_i   (n_pages),
    .cmd_valid_i (be_cmd_valid),
    .cmd_i       (be_cmd),
    .cmd_ready_o (be_cmd_ready),
    .clearing_o  (clearing),
    .result      (result_o)
  );

  // No item may enter while the page map is being cleared.
  a_no_item_while_clearing : assert property (
    @(posedge clk_i) disable iff (!rst_ni) clearing |-> !item_i.ready
  ) else $error("item transfer offered during the clearing pass");

  // A failed allocation reports a zero page address.
  a_oom_zero_address : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (result_o.valid && result_o.out_of_memory) |-> (result_o.page_address == '0)
  ) else $error("out-of-memory result carries a page address");

  // The free count never exceeds the number of pages in the map.
  a_free_count_bound : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      result_o.valid |-> (32'(result_o.free_pages) <= 32'(pba_pkg::MAX_PAGES))
  ) else $error("free page count above the map size");

  // A command is only taken by the back end outside the clearing pass.
  a_no_command_while_clearing : assert property (
    @(posedge clk_i) disable iff (!rst_ni) clearing |-> !be_cmd_ready
  ) else $error("command taken during the clearing pass");

endmodule

`default_nettype wire

FILE: design/pba_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; used for the page map.
`timescale 1ns / 1ps
`default_nettype none

module pba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                           wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/pba_front.sv
// Front end: accepts items, does the 64-bit range rounding and clipping,
// and issues one command per item. Depends on pba_pkg and pba_item_if.
`timescale 1ns / 1ps
`default_nettype none

module pba_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  pba_item_if.sink           item,
  input  wire pba_pkg::cnt_t n_pages_i,
  input  wire logic          block_i,
  output logic               cmd_valid_o,
  output pba_pkg::cmd_t      cmd_o,
  input  wire logic          cmd_ready_i
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CALC = 3'b010,
    F_PUSH = 3'b100
  } fstate_e;

  fstate_e        state_q, state_d;
  pba_pkg::kind_t kind_q;
  pba_pkg::addr_t base_q;
  pba_pkg::addr_t len_q;
  pba_pkg::addr_t sum_q, sum_d;
  pba_pkg::pn_t   start_r_q, start_r_d;
  pba_pkg::pn_t   start_f_q, start_f_d;
  logic           len_zero_q, len_zero_d;

  logic           accept;
  pba_pkg::addr_t round_up;
  pba_pkg::addr_t end_sum;
  pba_pkg::pn_t   first_pn;
  pba_pkg::pn_t   last_pn;
  pba_pkg::pn_t   last_clip;
  pba_pkg::pn_t   n_pn;
  logic           skip;

  assign item.ready = (state_q == F_IDLE) && !block_i;
  assign accept     = item.valid && item.ready;

  // First stage of the address arithmetic: the range end and the rounded-up base.
  always_comb begin
    round_up   = base_q + pba_pkg::PAGE_ROUND;
    sum_d      = base_q + len_q;
    start_r_d  = base_q[pba_pkg::ADDR_W-1:pba_pkg::PAGE_SHIFT];
    start_f_d  = round_up[pba_pkg::ADDR_W-1:pba_pkg::PAGE_SHIFT];
    len_zero_d = (len_q == '0);
  end

  // Second stage: page bounds for each kind, clipped to the managed pages.
  always_comb begin
    end_sum  = sum_q + pba_pkg::PAGE_ROUND;
    n_pn     = pba_pkg::pn_t'(n_pages_i);
    first_pn = '0;
    last_pn  = '0;
    skip     = 1'b1;
    case (pba_pkg::kind_e'(kind_q))
      pba_pkg::KIND_RESERVE: begin
        first_pn = start_r_q;
        last_pn  = end_sum[pba_pkg::ADDR_W-1:pba_pkg::PAGE_SHIFT];
        skip     = len_zero_q;
      end
      pba_pkg::KIND_RELEASE: begin
        first_pn = start_f_q;
        last_pn  = sum_q[pba_pkg::ADDR_W-1:pba_pkg::PAGE_SHIFT];
        skip     = len_zero_q || (last_pn < start_f_q);
      end
      pba_pkg::KIND_FREE_ONE: begin
        first_pn = pba_pkg::pn_t'(base_q[pba_pkg::PAGE_ADDR_W-1:pba_pkg::PAGE_SHIFT]);
        last_pn  = first_pn + pba_pkg::pn_t'(1);
        skip     = 1'b0;
      end
      default: begin
        skip = 1'b0;
      end
    endcase
    last_clip = (last_pn > n_pn) ? n_pn : last_pn;

    cmd_o = '{op: pba_pkg::OP_NOP, lo: '0, hi: '0};
    if (pba_pkg::kind_e'(kind_q) == pba_pkg::KIND_ALLOC) begin
      cmd_o.op = pba_pkg::OP_ALLOC;
    end else if (!skip && (first_pn < last_clip)) begin
      cmd_o.op = (pba_pkg::kind_e'(kind_q) == pba_pkg::KIND_RESERVE) ?
                 pba_pkg::OP_MARK : pba_pkg::OP_CLEAR;
      cmd_o.lo = pba_pkg::cnt_t'(first_pn);
      cmd_o.hi = pba_pkg::cnt_t'(last_clip);
    end
  end

  assign cmd_valid_o = (state_q == F_PUSH);

  // Sequencing of one item through the two arithmetic stages.
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          state_d = F_CALC;
        end
      end
      F_CALC: begin
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (cmd_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Item and intermediate results; no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= item.kind;
      base_q <= item.address;
      len_q  <= item.length;
    end
    if (state_q == F_CALC) begin
      sum_q      <= sum_d;
      start_r_q  <= start_r_d;
      start_f_q  <= start_f_d;
      len_zero_q <= len_zero_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/pba_cmd_q.sv
// Short command queue that decouples the front end from the back end.
// Depends on pba_pkg for the command type and the queue depth.
`timescale 1ns / 1ps
`default_nettype none

module pba_cmd_q (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  input  wire pba_pkg::cmd_t push_cmd_i,
  output logic               push_ready_o,
  output logic               pop_valid_o,
  output pba_pkg::cmd_t      pop_cmd_o,
  input  wire logic          pop_ready_i
);

  pba_pkg::cmd_t  slot_q [pba_pkg::QUEUE_DEPTH];
  pba_pkg::qptr_t wr_ptr_q, wr_ptr_d;
  pba_pkg::qptr_t rd_ptr_q, rd_ptr_d;
  pba_pkg::qcnt_t fill_q, fill_d;
  logic           push, pop;

  assign push_ready_o = (fill_q != pba_pkg::qcnt_t'(pba_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_cmd_o    = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill updates with explicit wrap.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == pba_pkg::qptr_t'(pba_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + pba_pkg::qptr_t'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == pba_pkg::qptr_t'(pba_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + pba_pkg::qptr_t'(1);
    end
    if (push && !pop) begin
      fill_d = fill_q + pba_pkg::qcnt_t'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - pba_pkg::qcnt_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

FILE: design/pba_back.sv
// Back end: clears the page map after reset, then carries out commands by
// read-modify-write of one map byte at a time. Depends on pba_pkg, pba_ram
// and pba_result_if.
`timescale 1ns / 1ps
`default_nettype none

module pba_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire pba_pkg::cnt_t n_pages_i,
  input  wire logic          cmd_valid_i,
  input  wire pba_pkg::cmd_t cmd_i,
  output logic               cmd_ready_o,
  output logic               clearing_o,
  pba_result_if.source       result
);

  typedef enum logic [5:0] {
    B_CLEAR  = 6'b000001,
    B_IDLE   = 6'b000010,
    B_START  = 6'b000100,
    B_READ   = 6'b001000,
    B_MODIFY = 6'b010000,
    B_REPORT = 6'b100000
  } bstate_e;

  bstate_e             state_q, state_d;
  pba_pkg::op_e        op_q, op_d;
  pba_pkg::cnt_t       lo_q, lo_d;
  pba_pkg::cnt_t       hi_q, hi_d;
  pba_pkg::pidx_t      p0_q, p0_d;
  logic                wrapped_q, wrapped_d;
  pba_pkg::map_addr_t  byte_q, byte_d;
  pba_pkg::pidx_t      cursor_q, cursor_d;
  pba_pkg::cnt_t       count_q, count_d;
  logic                oom_q, oom_d;
  pba_pkg::page_addr_t paddr_q, paddr_d;
  logic                res_valid_q, res_valid_d;
  pba_pkg::page_addr_t res_paddr_q;
  logic                res_oom_q;
  pba_pkg::cnt_t       res_free_q;
  logic                res_load;

  logic                ram_we;
  pba_pkg::map_byte_t  ram_wdata;
  pba_pkg::map_byte_t  ram_rdata;

  pba_pkg::map_byte_t  mask;
  pba_pkg::map_byte_t  free_bits;
  pba_pkg::map_byte_t  changed;
  pba_pkg::bit_idx_t   low_idx;
  logic                found;
  pba_pkg::cnt_t       pop;
  logic [31:0]         page_j;
  pba_pkg::pidx_t      start_page;
  pba_pkg::pidx_t      alloc_page;
  pba_pkg::map_addr_t  first_byte;
  pba_pkg::map_addr_t  last_byte;
  logic                out_free;

  pba_ram #(
    .WIDTH (pba_pkg::BYTE_W),
    .DEPTH (pba_pkg::MAP_DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (byte_q),
    .wdata_i (ram_wdata),
    .raddr_i (byte_q),
    .rdata_o (ram_rdata)
  );

  // Per-byte view: which pages of this byte lie in [lo, hi), and what changes.
  always_comb begin
    page_j    = '0;
    mask      = '0;
    low_idx   = '0;
    pop       = '0;
    for (int j = 0; j < pba_pkg::BYTE_W; j++) begin
      page_j  = 32'({byte_q, pba_pkg::bit_idx_t'(j)});
      mask[j] = (page_j >= 32'(lo_q)) && (page_j < 32'(hi_q));
    end
    free_bits = ~ram_rdata & mask;
    found     = |free_bits;
    for (int j = pba_pkg::BYTE_W - 1; j >= 0; j--) begin
      if (free_bits[j]) begin
        low_idx = pba_pkg::bit_idx_t'(j);
      end
    end
    changed = (op_q == pba_pkg::OP_CLEAR) ? (ram_rdata & mask) : free_bits;
    for (int j = 0; j < pba_pkg::BYTE_W; j++) begin
      pop = pop + pba_pkg::cnt_t'(changed[j]);
    end
  end

  // Next-fit start point, the page an allocation takes, and the walk bounds.
  always_comb begin
    start_page = (32'(cursor_q) >= 32'(n_pages_i)) ? '0 : cursor_q;
    alloc_page = pba_pkg::pidx_t'({byte_q, low_idx});
    first_byte = pba_pkg::map_addr_t'(32'(lo_q) >> pba_pkg::BIT_IDX_W);
    last_byte  = pba_pkg::map_addr_t'((32'(hi_q) - 32'd1) >> pba_pkg::BIT_IDX_W);
  end

  assign out_free    = !res_valid_q || result.ready;
  assign cmd_ready_o = (state_q == B_IDLE);
  assign clearing_o  = (state_q == B_CLEAR);

  // Command sequencer.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    p0_d        = p0_q;
    wrapped_d   = wrapped_q;
    byte_d      = byte_q;
    cursor_d    = cursor_q;
    count_d     = count_q;
    oom_d       = oom_q;
    paddr_d     = paddr_q;
    ram_we      = 1'b0;
    ram_wdata   = ram_rdata;
    res_load    = 1'b0;
    res_valid_d = res_valid_q;
    if (res_valid_q && result.ready) begin
      res_valid_d = 1'b0;
    end

    case (state_q)
      // Write every map byte as all pages used.
      B_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '1;
        if (byte_q == pba_pkg::map_addr_t'(pba_pkg::MAP_DEPTH - 1)) begin
          byte_d  = '0;
          state_d = B_IDLE;
        end else begin
          byte_d = byte_q + pba_pkg::map_addr_t'(1);
        end
      end
      B_IDLE: begin
        if (cmd_valid_i) begin
          op_d      = cmd_i.op;
          oom_d     = 1'b0;
          paddr_d   = '0;
          wrapped_d = 1'b0;
          p0_d      = start_page;
          lo_d      = cmd_i.lo;
          hi_d      = cmd_i.hi;
          if (cmd_i.op == pba_pkg::OP_ALLOC) begin
            lo_d = pba_pkg::cnt_t'(start_page);
            hi_d = n_pages_i;
          end else if (cmd_i.op == pba_pkg::OP_NOP) begin
            lo_d = '0;
            hi_d = '0;
          end
          state_d = B_START;
        end
      end
      // Begin a walk, or for an allocation wrap round to the pages below the start.
      B_START: begin
        if (lo_q < hi_q) begin
          byte_d  = first_byte;
          state_d = B_READ;
        end else if ((op_q == pba_pkg::OP_ALLOC) && !wrapped_q && (p0_q != '0)) begin
          lo_d      = '0;
          hi_d      = pba_pkg::cnt_t'(p0_q);
          wrapped_d = 1'b1;
        end else begin
          if (op_q == pba_pkg::OP_ALLOC) begin
            oom_d    = 1'b1;
            cursor_d = p0_q;
          end
          state_d = B_REPORT;
        end
      end
      B_READ: begin
        state_d = B_MODIFY;
      end
      // Update the byte just read and move on.
      B_MODIFY: begin
        case (op_q)
          pba_pkg::OP_MARK: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | mask;
            count_d   = count_q - pop;
          end
          pba_pkg::OP_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata & ~mask;
            count_d   = count_q + pop;
          end
          pba_pkg::OP_ALLOC: begin
            if (found) begin
              ram_we    = 1'b1;
              ram_wdata = ram_rdata | (pba_pkg::map_byte_t'(1) << low_idx);
              count_d   = count_q - pba_pkg::cnt_t'(1);
              cursor_d  = ((32'(alloc_page) + 32'd1) < 32'(n_pages_i)) ?
                          pba_pkg::pidx_t'(32'(alloc_page) + 32'd1) : '0;
              paddr_d   = pba_pkg::page_addr_t'(64'(alloc_page) << pba_pkg::PAGE_SHIFT);
            end
          end
          default: begin
          end
        endcase
        if ((op_q == pba_pkg::OP_ALLOC) && found) begin
          state_d = B_REPORT;
        end else if (byte_q == last_byte) begin
          lo_d    = hi_q;
          state_d = B_START;
        end else begin
          byte_d  = byte_q + pba_pkg::map_addr_t'(1);
          state_d = B_READ;
        end
      end
      // Hand the result to the output register once it is free.
      B_REPORT: begin
        if (out_free) begin
          res_load    = 1'b1;
          res_valid_d = 1'b1;
          state_d     = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      op_q        <= pba_pkg::OP_NOP;
      lo_q        <= '0;
      hi_q        <= '0;
      p0_q        <= '0;
      wrapped_q   <= 1'b0;
      byte_q      <= '0;
      cursor_q    <= '0;
      count_q     <= '0;
      oom_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      p0_q        <= p0_d;
      wrapped_q   <= wrapped_d;
      byte_q      <= byte_d;
      cursor_q    <= cursor_d;
      count_q     <= count_d;
      oom_q       <= oom_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    paddr_q <= paddr_d;
    if (res_load) begin
      res_paddr_q <= paddr_q;
      res_oom_q   <= oom_q;
      res_free_q  <= count_q;
    end
  end

  assign result.valid         = res_valid_q;
  assign result.page_address  = res_paddr_q;
  assign result.out_of_memory = res_oom_q;
  assign result.free_pages    = pba_pkg::free_t'(res_free_q);

endmodule

`default_nettype wire
